// File: hdl/jbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types and constants for the JSON byte tokeniser.
// ----------------------------------------------------------------------------
package jbt_pkg;

    // Byte codes the lexer reacts to
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;

    // Token kinds
    localparam logic [3:0] KIND_LBRACE = 4'd0;
    localparam logic [3:0] KIND_RBRACE = 4'd1;
    localparam logic [3:0] KIND_LBRACK = 4'd2;
    localparam logic [3:0] KIND_RBRACK = 4'd3;
    localparam logic [3:0] KIND_COLON  = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_STRING = 4'd6;
    localparam logic [3:0] KIND_BOOL   = 4'd7;
    localparam logic [3:0] KIND_NULL   = 4'd8;
    localparam logic [3:0] KIND_NUMBER = 4'd9;
    localparam logic [3:0] KIND_NONE   = 4'd0;   // kind field on error events

    // Event codes
    localparam logic [1:0] EV_CONTENT  = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_ERROR    = 2'd2;

    // Literal words
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // Result queue depth
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);

    // One result word
    typedef struct packed {
        logic [3:0] token_kind;
        logic [1:0] event_res;
        logic [7:0] byte_value;
        logic       last_of_run;
    } t_result;

    // Results produced by one input byte
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_lex_out;

    // Expected letter after the first one of true / false / null
    function automatic logic [7:0] word_tail(input logic [1:0] which, input logic [1:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (which)
            LIT_TRUE: begin
                case (pos)
                    2'd0:    ch = 8'h72;
                    2'd1:    ch = 8'h75;
                    2'd2:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                case (pos)
                    2'd0:    ch = 8'h61;
                    2'd1:    ch = 8'h6C;
                    2'd2:    ch = 8'h73;
                    default: ch = 8'h65;
                endcase
            end
            default: begin
                case (pos)
                    2'd0:    ch = 8'h75;
                    2'd1:    ch = 8'h6C;
                    2'd2:    ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: hdl/jbt_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_lexer
// Scan state and per-byte decode: yields up to two results for each word.
// ----------------------------------------------------------------------------
module jbt_lexer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_acc,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eoi,
    output jbt_pkg::t_lex_out    o_res
);
    import jbt_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE    = 5'b00001,
        M_STRING  = 5'b00010,
        M_LITERAL = 5'b00100,
        M_NUMBER  = 5'b01000,
        M_ERROR   = 5'b10000
    } t_mode;

    typedef struct packed {
        logic       valid;
        t_result    res;
        t_mode      mode;
        logic       set_lit;
        logic [1:0] which;
    } t_fresh;

    t_mode      r_mode,  n_mode;
    logic [1:0] r_which, n_which;
    logic [2:0] r_pos,   n_pos;
    logic       r_bs,    n_bs;

    // Byte seen with no token open
    function automatic t_fresh fresh(input logic [7:0] b);
        t_fresh f;
        f = '0;
        f.mode = M_IDLE;
        f.res.event_res = EV_COMPLETE;
        case (b)
            CH_LBRACE: begin f.valid = 1'b1; f.res.token_kind = KIND_LBRACE; end
            CH_RBRACE: begin f.valid = 1'b1; f.res.token_kind = KIND_RBRACE; end
            CH_LBRACK: begin f.valid = 1'b1; f.res.token_kind = KIND_LBRACK; end
            CH_RBRACK: begin f.valid = 1'b1; f.res.token_kind = KIND_RBRACK; end
            CH_COLON:  begin f.valid = 1'b1; f.res.token_kind = KIND_COLON;  end
            CH_COMMA:  begin f.valid = 1'b1; f.res.token_kind = KIND_COMMA;  end
            CH_QUOTE:  f.mode = M_STRING;
            CH_T: begin f.mode = M_LITERAL; f.set_lit = 1'b1; f.which = LIT_TRUE;  end
            CH_F: begin f.mode = M_LITERAL; f.set_lit = 1'b1; f.which = LIT_FALSE; end
            CH_N: begin f.mode = M_LITERAL; f.set_lit = 1'b1; f.which = LIT_NULL;  end
            default: begin
                if (b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
                    f.valid = 1'b0;
                end else if (b inside {[CH_ZERO:CH_NINE]}) begin
                    f.mode  = M_NUMBER;
                    f.valid = 1'b1;
                    f.res   = '{KIND_NUMBER, EV_CONTENT, b, 1'b0};
                end else begin
                    f.mode  = M_ERROR;
                    f.valid = 1'b1;
                    f.res   = '{KIND_NONE, EV_ERROR, b, 1'b0};
                end
            end
        endcase
        return f;
    endfunction

    // Decode of the current word against the scan state
    always_comb begin
        t_fresh     fr;
        t_result    ra, rb, rc;
        logic       va, vb, vc;
        logic [2:0] len;
        logic [2:0] pnext;
        logic       fresh_a, fresh_b;

        n_mode  = r_mode;
        n_which = r_which;
        n_pos   = r_pos;
        n_bs    = r_bs;
        ra = '0; rb = '0; rc = '0;
        va = 1'b0; vb = 1'b0; vc = 1'b0;
        fresh_a = 1'b0;
        fresh_b = 1'b0;
        fr    = fresh(i_byte);
        len   = (r_which == LIT_FALSE) ? 3'd4 : 3'd3;
        pnext = r_pos + 3'd1;

        case (r_mode)
            M_STRING: begin
                va = 1'b1;
                if (i_byte == CH_QUOTE && !r_bs) begin
                    ra     = '{KIND_STRING, EV_COMPLETE, 8'h00, 1'b0};
                    n_mode = M_IDLE;
                    n_bs   = 1'b0;
                end else begin
                    ra   = '{KIND_STRING, EV_CONTENT, i_byte, 1'b0};
                    n_bs = (i_byte == CH_BSLASH) && !r_bs;
                end
            end
            M_LITERAL: begin
                va = 1'b1;
                if (r_pos < len && i_byte == word_tail(r_which, r_pos[1:0])) begin
                    n_pos = pnext;
                    va    = (pnext >= len);
                    if (pnext >= len) begin
                        if (r_which == LIT_TRUE)
                            ra = '{KIND_BOOL, EV_COMPLETE, 8'h01, 1'b0};
                        else if (r_which == LIT_FALSE)
                            ra = '{KIND_BOOL, EV_COMPLETE, 8'h00, 1'b0};
                        else
                            ra = '{KIND_NULL, EV_COMPLETE, 8'h00, 1'b0};
                        n_mode = M_IDLE;
                        n_pos  = 3'd0;
                    end
                end else begin
                    ra     = '{KIND_NONE, EV_ERROR, i_byte, 1'b0};
                    n_mode = M_ERROR;
                end
            end
            M_NUMBER: begin
                va = 1'b1;
                if ((i_byte inside {[CH_ZERO:CH_NINE]}) || i_byte == CH_DOT) begin
                    ra = '{KIND_NUMBER, EV_CONTENT, i_byte, 1'b0};
                end else begin
                    // terminator closes the number, then starts afresh
                    ra      = '{KIND_NUMBER, EV_COMPLETE, 8'h00, 1'b0};
                    fresh_b = 1'b1;
                end
            end
            M_ERROR: begin
                va = 1'b0;
            end
            default: begin
                fresh_a = 1'b1;
            end
        endcase

        if (fresh_a || fresh_b) begin
            n_mode = fr.mode;
            if (fr.mode == M_STRING)
                n_bs = 1'b0;
            if (fr.set_lit) begin
                n_which = fr.which;
                n_pos   = 3'd0;
            end
        end
        if (fresh_a) begin
            va = fr.valid;
            ra = fr.res;
        end
        if (fresh_b) begin
            vb = fr.valid;
            rb = fr.res;
        end

        // End of input closes any open string or number, flags an open literal as an error, and clears state
        if (i_eoi) begin
            case (n_mode)
                M_STRING:  begin vc = 1'b1; rc = '{KIND_STRING, EV_COMPLETE, 8'h00, 1'b0}; end
                M_NUMBER:  begin vc = 1'b1; rc = '{KIND_NUMBER, EV_COMPLETE, 8'h00, 1'b0}; end
                M_LITERAL: begin vc = 1'b1; rc = '{KIND_NONE, EV_ERROR, i_byte, 1'b0}; end
                default:   vc = 1'b0;
            endcase
            n_mode  = M_IDLE;
            n_which = 2'd0;
            n_pos   = 3'd0;
            n_bs    = 1'b0;
        end

        // Keep the first two results in order
        o_res = '0;
        if (va) begin
            o_res.slot0 = ra;
            if (vb) begin
                o_res.slot1 = rb; o_res.count = 2'd2;
            end else if (vc) begin
                o_res.slot1 = rc; o_res.count = 2'd2;
            end else begin
                o_res.count = 2'd1;
            end
        end else if (vb) begin
            o_res.slot0 = rb;
            if (vc) begin
                o_res.slot1 = rc; o_res.count = 2'd2;
            end else begin
                o_res.count = 2'd1;
            end
        end else if (vc) begin
            o_res.slot0 = rc; o_res.count = 2'd1;
        end
        if (o_res.count == 2'd2)
            o_res.slot1.last_of_run = 1'b1;
        else if (o_res.count == 2'd1)
            o_res.slot0.last_of_run = 1'b1;
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_which <= 2'd0;
            r_pos   <= 3'd0;
            r_bs    <= 1'b0;
        end else if (i_acc) begin
            r_mode  <= n_mode;
            r_which <= n_which;
            r_pos   <= n_pos;
            r_bs    <= n_bs;
        end
    end

endmodule
`default_nettype wire

// File: hdl/jbt_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_res_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module jbt_res_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire jbt_pkg::t_lex_out  i_res,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_pop,
    output jbt_pkg::t_result        o_res
);
    import jbt_pkg::*;

    t_result           r_mem [RES_DEPTH];
    logic [RES_AW-1:0] r_wp, n_wp;
    logic [RES_AW-1:0] r_rp, n_rp;
    logic [RES_AW:0]   r_cnt, n_cnt;
    logic [1:0]        push_n;
    logic              pop_go;

    assign push_n  = i_push ? i_res.count : 2'd0;
    assign o_valid = (r_cnt != '0);
    assign pop_go  = o_valid && i_pop;
    assign o_room  = (r_cnt <= (RES_AW+1)'(RES_DEPTH - 2));
    assign o_res   = r_mem[r_rp];

    // Pointer and fill count update
    always_comb begin
        n_wp  = r_wp + RES_AW'(push_n);
        n_rp  = r_rp + RES_AW'(pop_go);
        n_cnt = r_cnt + (RES_AW+1)'(push_n) - (RES_AW+1)'(pop_go);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0)
            r_mem[r_wp] <= i_res.slot0;
        if (push_n == 2'd2)
            r_mem[r_wp + RES_AW'(1)] <= i_res.slot1;
    end

endmodule
`default_nettype wire

// File: hdl/json_byte_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_byte_tokenizer_core
// JSON lexer taking one text byte per word and emitting token events.
//
//  Channel   Dir  tdata            tuser                          tlast
//  s_axis    in   [7:0] data_byte  -                              end_of_input
//  m_axis    out  [7:0] byte_value [3:0] token_kind,[5:4] event_res last_of_run
//
// A byte is decoded in the cycle it is taken; its results enter a four-deep
// result queue and leave one per cycle while m_axis_tready is high. One byte
// per cycle is sustained while each byte gives at most one result and output
// does not stall; s_axis_tready drops while the queue holds over two results.
// Synchronous active-low reset returns the scanner to idle and empties the
// queue. Output stalls back up the queue and can so drop s_axis_tready.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic       i_s_axis_tlast,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] byte_value
    output logic [5:0]      o_m_axis_tuser,   // [3:0] token_kind, [5:4] event_res
    output logic            o_m_axis_tlast
);
    import jbt_pkg::*;

    logic     room;
    logic     acc;
    t_lex_out lex_res;
    t_result  head;

    assign o_s_axis_tready = room;
    assign acc             = i_s_axis_tvalid && room;

    // Per-byte decode
    jbt_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_byte  (i_s_axis_tdata),
        .i_eoi   (i_s_axis_tlast),
        .o_res   (lex_res)
    );

    // Result queue
    jbt_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_res   (lex_res),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_pop   (i_m_axis_tready),
        .o_res   (head)
    );

    assign o_m_axis_tdata = head.byte_value;
    assign o_m_axis_tuser = {head.event_res, head.token_kind};
    assign o_m_axis_tlast = head.last_of_run;

endmodule
`default_nettype wire
